/* rtl/slpi_pkg.sv */
package slpi_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CODE_W        = 4;

    localparam logic [CODE_W-1:0] CODE_READY = 4'd12;
    localparam logic [CODE_W-1:0] CODE_INIT  = 4'd9;

    localparam logic [15:0] SLOW_RST  = 16'd500;
    localparam logic [15:0] PAUSE_RST = 16'd1500;
    localparam logic [15:0] IDLE_RST  = 16'd2000;

    localparam logic [1:0] CFG_SLOW  = 2'd0;
    localparam logic [1:0] CFG_PAUSE = 2'd1;
    localparam logic [1:0] CFG_IDLE  = 2'd2;

    localparam logic [2:0] LED_OFF = 3'b000;
    localparam logic [2:0] LED_R   = 3'b001;
    localparam logic [2:0] LED_Y   = 3'b010;
    localparam logic [2:0] LED_G   = 3'b100;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_STEADY = 2'd0,
        K_BLINK  = 2'd1,
        K_NONE   = 2'd2,
        K_WAIT   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [2:0] rank;
        t_kind      kind;
        logic [2:0] led;
        logic [2:0] count;
    } t_info;

    typedef struct packed {
        logic [15:0] slow;
        logic [15:0] pause;
        logic [15:0] idle;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic              empty;
        logic              step;
        logic [CODE_W-1:0] code;
    } t_seq_cmd;

    typedef struct packed {
        logic at_start;
        logic left_zero;
    } t_seq_stat;

    function automatic t_info code_info(input logic [CODE_W-1:0] code);
        t_info r;
        case (code)
            4'd0:    r = '{3'd6, K_STEADY, LED_R, 3'd0};
            4'd1:    r = '{3'd5, K_BLINK,  LED_R, 3'd2};
            4'd2:    r = '{3'd5, K_BLINK,  LED_R, 3'd3};
            4'd3:    r = '{3'd4, K_STEADY, LED_Y, 3'd0};
            4'd4:    r = '{3'd3, K_BLINK,  LED_Y, 3'd1};
            4'd5:    r = '{3'd3, K_BLINK,  LED_Y, 3'd2};
            4'd6:    r = '{3'd3, K_BLINK,  LED_Y, 3'd3};
            4'd7:    r = '{3'd3, K_BLINK,  LED_Y, 3'd4};
            4'd8:    r = '{3'd2, K_STEADY, LED_G, 3'd0};
            4'd9:    r = '{3'd2, K_BLINK,  LED_G, 3'd1};
            4'd10:   r = '{3'd2, K_BLINK,  LED_G, 3'd2};
            4'd11:   r = '{3'd2, K_BLINK,  LED_G, 3'd3};
            4'd12:   r = '{3'd1, K_NONE,   LED_OFF, 3'd0};
            4'd13:   r = '{3'd1, K_NONE,   LED_OFF, 3'd0};
            default: r = '{3'd1, K_WAIT,   LED_OFF, 3'd0};
        endcase
        return r;
    endfunction

endpackage

/* rtl/slpi_table_ram.sv */
module slpi_table_ram
    import slpi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [CODE_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [CODE_W-1:0]        o_rdata
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/slpi_seq.sv */
module slpi_seq
    import slpi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_seq_cmd  i_cmd,
    output t_seq_stat o_stat,
    output logic [2:0] o_led
);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ON    = 3'd1,
        PH_OFF   = 3'd2,
        PH_IDLE  = 3'd3,
        PH_PAUSE = 3'd4,
        PH_EMPTY = 3'd5
    } t_phase;

    t_phase            r_phase,  n_phase;
    logic [15:0]       r_left,   n_left;
    logic [2:0]        r_blinks, n_blinks;
    logic [CODE_W-1:0] r_shown,  n_shown;
    logic [2:0]        r_led,    n_led;
    t_info             info_s;
    t_info             info_c;
    logic [2:0]        blinks_dec;

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_blinks   = r_blinks;
        n_shown    = r_shown;
        n_led      = r_led;
        info_s     = code_info(i_cmd.code);
        info_c     = code_info(r_shown);
        blinks_dec = (r_blinks != 3'd0) ? r_blinks - 3'd1 : 3'd0;
        if (i_cmd.start) begin
            n_led = LED_OFF;
            if (i_cmd.empty) begin
                n_phase = PH_EMPTY;
                n_left  = i_cfg.idle;
            end else begin
                n_shown = i_cmd.code;
                case (info_s.kind)
                    K_STEADY: begin
                        n_led   = info_s.led;
                        n_phase = PH_PAUSE;
                        n_left  = i_cfg.pause;
                    end
                    K_BLINK: begin
                        n_blinks = info_s.count;
                        n_led    = info_s.led;
                        n_phase  = PH_ON;
                        n_left   = i_cfg.slow;
                    end
                    K_WAIT: begin
                        n_phase = PH_IDLE;
                        n_left  = i_cfg.idle;
                    end
                    default: begin
                        n_phase = PH_PAUSE;
                        n_left  = i_cfg.pause;
                    end
                endcase
            end
        end else if (i_cmd.step) begin
            if (r_left != 16'd0) begin
                n_left = r_left - 16'd1;
            end else begin
                case (r_phase)
                    PH_ON: begin
                        n_led   = r_led & ~info_c.led;
                        n_phase = PH_OFF;
                        n_left  = i_cfg.slow;
                    end
                    PH_OFF: begin
                        n_blinks = blinks_dec;
                        if (blinks_dec != 3'd0) begin
                            n_led   = r_led | info_c.led;
                            n_phase = PH_ON;
                            n_left  = i_cfg.slow;
                        end else begin
                            n_phase = PH_PAUSE;
                            n_left  = i_cfg.pause;
                        end
                    end
                    PH_IDLE: begin
                        n_phase = PH_PAUSE;
                        n_left  = i_cfg.pause;
                    end
                    default: begin
                        n_phase = PH_START;
                        n_left  = 16'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_left   <= 16'd0;
            r_blinks <= 3'd0;
            r_shown  <= '0;
            r_led    <= LED_OFF;
        end else begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_blinks <= n_blinks;
            r_shown  <= n_shown;
            r_led    <= n_led;
        end
    end

    assign o_stat = '{
        at_start:  !(r_phase == PH_ON || r_phase == PH_OFF || r_phase == PH_IDLE
                     || r_phase == PH_PAUSE || r_phase == PH_EMPTY),
        left_zero: (r_left == 16'd0)
    };
    assign o_led  = r_led;

endmodule

/* rtl/status_led_priority_indicator.sv */
// Add/remove/query walk the table, then pass through a decision step, an optional shift, an
// optional append and a result step. Ticks step the sequencer, with a table walk for each
// pattern start, then load a result. One item at a time: the next beat is taken the cycle
// after the result loads; a result waits to load while the previous result is still unaccepted.
// Reset is synchronous; the first cycle after reset writes the initial code into entry 0.
module status_led_priority_indicator
    import slpi_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_status_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_led_red,
    output logic        o_led_yellow,
    output logic        o_led_green,
    output logic        o_status_found,
    output logic [4:0]  o_entry_count,
    output logic        o_insert_dropped,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_INIT   = 3'd0,
        S_IDLE   = 3'd1,
        S_SCAN   = 3'd2,
        S_APPLY  = 3'd3,
        S_SHIFT  = 3'd4,
        S_APPEND = 3'd5,
        S_TICK   = 3'd6,
        S_DONE   = 3'd7
    } t_state;

    t_state            r_state,   n_state;
    t_op               r_op,      n_op;
    logic [CODE_W-1:0] r_code,    n_code;
    logic [CW-1:0]     r_count,   n_count;
    logic              r_started, n_started;
    logic [CW-1:0]     r_rd,      n_rd;
    logic              r_rv,      n_rv;
    logic [AW-1:0]     r_ra,      n_ra;
    logic              r_chit,    n_chit;
    logic [AW-1:0]     r_cpos,    n_cpos;
    logic              r_rhit,    n_rhit;
    logic [AW-1:0]     r_rpos,    n_rpos;
    logic [CODE_W-1:0] r_best,    n_best;
    logic [2:0]        r_brank,   n_brank;
    logic              r_found,   n_found;
    logic              r_drop,    n_drop;
    logic              r_ovalid,  n_ovalid;
    logic [2:0]        r_o_led,   n_o_led;
    logic              r_o_found, n_o_found;
    logic [4:0]        r_o_count, n_o_count;
    logic              r_o_drop,  n_o_drop;
    t_cfg              r_cfg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CODE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [CODE_W-1:0] ram_rdata;
    logic              issue;
    t_info             rd_info;
    t_seq_cmd          seq_cmd;
    t_seq_stat         seq_stat;
    logic [2:0]        seq_led;

    slpi_table_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    slpi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (seq_cmd),
        .o_stat  (seq_stat),
        .o_led   (seq_led)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_code    = r_code;
        n_count   = r_count;
        n_started = r_started;
        n_rd      = r_rd;
        n_rv      = r_rv;
        n_ra      = r_ra;
        n_chit    = r_chit;
        n_cpos    = r_cpos;
        n_rhit    = r_rhit;
        n_rpos    = r_rpos;
        n_best    = r_best;
        n_brank   = r_brank;
        n_found   = r_found;
        n_drop    = r_drop;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_o_led   = r_o_led;
        n_o_found = r_o_found;
        n_o_count = r_o_count;
        n_o_drop  = r_o_drop;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        seq_cmd   = '0;
        issue     = (r_rd < r_count);
        rd_info   = code_info(ram_rdata);

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = CODE_INIT;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = t_op'(i_operation);
                    n_code    = i_status_code;
                    n_found   = 1'b0;
                    n_drop    = 1'b0;
                    n_started = 1'b0;
                    n_rd      = '0;
                    n_rv      = 1'b0;
                    n_chit    = 1'b0;
                    n_rhit    = 1'b0;
                    n_state   = (t_op'(i_operation) == OP_TICK) ? S_TICK : S_SCAN;
                end
            end
            S_SCAN: begin
                ram_re = issue;
                n_rv   = issue;
                n_ra   = r_rd[AW-1:0];
                if (issue) begin
                    n_rd = r_rd + 1'b1;
                end
                if (r_rv) begin
                    if (ram_rdata == r_code && !r_chit) begin
                        n_chit = 1'b1;
                        n_cpos = r_ra;
                    end
                    if (ram_rdata == CODE_READY && !r_rhit) begin
                        n_rhit = 1'b1;
                        n_rpos = r_ra;
                    end
                    if (r_ra == '0 || rd_info.rank > r_brank) begin
                        n_best  = ram_rdata;
                        n_brank = rd_info.rank;
                    end
                end
                if (!issue && !r_rv) begin
                    if (r_op == OP_TICK) begin
                        seq_cmd.start = 1'b1;
                        seq_cmd.code  = r_best;
                        n_state       = S_TICK;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_APPLY: begin
                n_rv = 1'b0;
                case (r_op)
                    OP_QUERY: begin
                        n_found = r_chit;
                        n_state = S_DONE;
                    end
                    OP_REMOVE: begin
                        if (r_chit) begin
                            n_rd    = CW'(r_cpos) + 1'b1;
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_ADD: begin
                        if (r_code != CODE_READY && r_rhit) begin
                            n_rd    = CW'(r_rpos) + 1'b1;
                            n_state = S_SHIFT;
                        end else if (!r_chit) begin
                            n_state = S_APPEND;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SHIFT: begin
                ram_re = issue;
                n_rv   = issue;
                n_ra   = r_rd[AW-1:0];
                if (issue) begin
                    n_rd = r_rd + 1'b1;
                end
                if (r_rv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ra - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (!issue && !r_rv) begin
                    n_count = r_count - 1'b1;
                    n_state = (r_op == OP_ADD && !r_chit) ? S_APPEND : S_DONE;
                end
            end
            S_APPEND: begin
                if (r_count < DEPTH_C) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[AW-1:0];
                    ram_wdata = r_code;
                    n_count   = r_count + 1'b1;
                end else begin
                    n_drop = 1'b1;
                end
                n_state = S_DONE;
            end
            S_TICK: begin
                if (seq_stat.at_start) begin
                    if (r_started) begin
                        n_state = S_DONE;
                    end else begin
                        n_started = 1'b1;
                        if (r_count == '0) begin
                            seq_cmd.start = 1'b1;
                            seq_cmd.empty = 1'b1;
                        end else begin
                            n_rd    = '0;
                            n_rv    = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                end else begin
                    seq_cmd.step = 1'b1;
                    if (!seq_stat.left_zero) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid  = 1'b1;
                    n_o_led   = seq_led;
                    n_o_found = r_found;
                    n_o_count = 5'(r_count);
                    n_o_drop  = r_drop;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_count   <= CW'(1);
            r_started <= 1'b0;
            r_rd      <= '0;
            r_rv      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_started <= n_started;
            r_rd      <= n_rd;
            r_rv      <= n_rv;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_code    <= n_code;
        r_ra      <= n_ra;
        r_chit    <= n_chit;
        r_cpos    <= n_cpos;
        r_rhit    <= n_rhit;
        r_rpos    <= n_rpos;
        r_best    <= n_best;
        r_brank   <= n_brank;
        r_found   <= n_found;
        r_drop    <= n_drop;
        r_o_led   <= n_o_led;
        r_o_found <= n_o_found;
        r_o_count <= n_o_count;
        r_o_drop  <= n_o_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow  <= SLOW_RST;
            r_cfg.pause <= PAUSE_RST;
            r_cfg.idle  <= IDLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLOW:  r_cfg.slow  <= i_cfg_data;
                CFG_PAUSE: r_cfg.pause <= i_cfg_data;
                CFG_IDLE:  r_cfg.idle  <= i_cfg_data;
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_led_red        = r_o_led[0];
    assign o_led_yellow     = r_o_led[1];
    assign o_led_green      = r_o_led[2];
    assign o_status_found   = r_o_found;
    assign o_entry_count    = r_o_count;
    assign o_insert_dropped = r_o_drop;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("active count above table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after beat accepted");

    a_found_query_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_op != OP_QUERY) |-> !r_found)
        else $error("found flag set for a non-query item");

    a_one_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(seq_led))
        else $error("more than one LED driven");

endmodule

/* tb/tb_status_led_priority_indicator.sv */
module tb_status_led_priority_indicator;
    import slpi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_DEPTH  = DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;

    localparam int MODE_MIXED = 0;
    localparam int MODE_STEADY = 1;
    localparam int MODE_FILL   = 2;

    typedef enum logic [2:0] {
        SEQ_START, SEQ_ON, SEQ_OFF, SEQ_IDLE, SEQ_PAUSE, SEQ_EMPTY
    } t_seq_phase;

    typedef struct packed {
        t_op        op;
        logic [3:0] code;
    } t_led_request;

    typedef struct packed {
        logic       red;
        logic       yellow;
        logic       green;
        logic       found;
        logic [4:0] count;
        logic       dropped;
    } t_led_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = OP_TICK;
    logic [3:0]  i_status_code = 4'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_led_red;
    logic        o_led_yellow;
    logic        o_led_green;
    logic        o_status_found;
    logic [4:0]  o_entry_count;
    logic        o_insert_dropped;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_SLOW;
    logic [15:0] i_cfg_data = 16'd0;

    t_led_request requests_pending[$];
    t_led_report  led_reports_due[$];
    int           fail_count = 0;
    int           quiet_cycles = 0;
    bit           steady_flow = 1'b0;

    logic [3:0]  active_codes[SET_DEPTH];
    int          active_len;
    t_seq_phase  seq_phase;
    logic [15:0] ticks_left;
    logic [2:0]  blinks_left;
    logic [3:0]  shown_code;
    logic [2:0]  lamps;
    logic [15:0] cfg_slow;
    logic [15:0] cfg_pause;
    logic [15:0] cfg_idle;

    status_led_priority_indicator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_status_code    (i_status_code),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_led_red        (o_led_red),
        .o_led_yellow     (o_led_yellow),
        .o_led_green      (o_led_green),
        .o_status_found   (o_status_found),
        .o_entry_count    (o_entry_count),
        .o_insert_dropped (o_insert_dropped),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int code_rank(logic [3:0] c);
        case (c)
            4'd0:                      return 100;
            4'd1, 4'd2:                return 90;
            4'd3:                      return 80;
            4'd4, 4'd5, 4'd6, 4'd7:    return 70;
            4'd8, 4'd9, 4'd10, 4'd11:  return 10;
            default:                   return 1;
        endcase
    endfunction

    function automatic t_kind code_style(logic [3:0] c);
        case (c)
            4'd0, 4'd3, 4'd8:  return K_STEADY;
            4'd12, 4'd13:      return K_NONE;
            4'd14, 4'd15:      return K_WAIT;
            default:           return K_BLINK;
        endcase
    endfunction

    function automatic logic [2:0] code_lamp(logic [3:0] c);
        if (c <= 4'd2) return LED_R;
        if (c <= 4'd7) return LED_Y;
        if (c <= 4'd11) return LED_G;
        return LED_OFF;
    endfunction

    function automatic logic [2:0] code_blinks(logic [3:0] c);
        case (c)
            4'd1:                return 3'd2;
            4'd2:                return 3'd3;
            4'd4, 4'd5, 4'd6, 4'd7: return 3'(c - 4'd3);
            4'd9, 4'd10, 4'd11:  return 3'(c - 4'd8);
            default:             return 3'd0;
        endcase
    endfunction

    function automatic int find_code(logic [3:0] c);
        for (int i = 0; i < active_len; i++) begin
            if (active_codes[i] == c) return i;
        end
        return -1;
    endfunction

    function automatic void close_gap(int pos);
        for (int j = pos; j + 1 < active_len; j++) begin
            active_codes[j] = active_codes[j + 1];
        end
        if (active_len > 0) active_len--;
    endfunction

    function automatic void start_pattern();
        logic [3:0] top;
        int         top_rank;
        lamps = LED_OFF;
        if (active_len == 0) begin
            seq_phase = SEQ_EMPTY;
            ticks_left = cfg_idle;
            return;
        end
        top = active_codes[0];
        top_rank = code_rank(top);
        for (int i = 1; i < active_len; i++) begin
            if (code_rank(active_codes[i]) > top_rank) begin
                top = active_codes[i];
                top_rank = code_rank(top);
            end
        end
        shown_code = top;
        case (code_style(top))
            K_STEADY: begin
                lamps = code_lamp(top);
                seq_phase = SEQ_PAUSE;
                ticks_left = cfg_pause;
            end
            K_BLINK: begin
                blinks_left = code_blinks(top);
                lamps = code_lamp(top);
                seq_phase = SEQ_ON;
                ticks_left = cfg_slow;
            end
            K_WAIT: begin
                seq_phase = SEQ_IDLE;
                ticks_left = cfg_idle;
            end
            default: begin
                seq_phase = SEQ_PAUSE;
                ticks_left = cfg_pause;
            end
        endcase
    endfunction

    function automatic void close_phase();
        logic [2:0] lamp;
        lamp = code_lamp(shown_code);
        case (seq_phase)
            SEQ_ON: begin
                lamps = lamps & ~lamp;
                seq_phase = SEQ_OFF;
                ticks_left = cfg_slow;
            end
            SEQ_OFF: begin
                if (blinks_left > 0) blinks_left--;
                if (blinks_left > 0) begin
                    lamps = lamps | lamp;
                    seq_phase = SEQ_ON;
                    ticks_left = cfg_slow;
                end else begin
                    seq_phase = SEQ_PAUSE;
                    ticks_left = cfg_pause;
                end
            end
            SEQ_IDLE: begin
                seq_phase = SEQ_PAUSE;
                ticks_left = cfg_pause;
            end
            default: begin
                seq_phase = SEQ_START;
                ticks_left = 16'd0;
            end
        endcase
    endfunction

    function automatic void advance_tick();
        bit started;
        started = 1'b0;
        for (int g = 0; g < 32; g++) begin
            // stop at a second pattern start; the next tick takes it
            if (seq_phase == SEQ_START) begin
                if (started) return;
                started = 1'b1;
                start_pattern();
            end
            if (ticks_left != 16'd0) begin
                ticks_left--;
                return;
            end
            close_phase();
        end
    endfunction

    function automatic t_led_report next_led_state(t_op op, logic [3:0] c);
        t_led_report r;
        int          pos;
        r = '0;
        case (op)
            OP_TICK: advance_tick();
            OP_ADD: begin
                if (c != CODE_READY) begin
                    pos = find_code(CODE_READY);
                    if (pos >= 0) close_gap(pos);
                end
                if (find_code(c) < 0) begin
                    if (active_len < SET_DEPTH) begin
                        active_codes[active_len] = c;
                        active_len++;
                    end else begin
                        r.dropped = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                pos = find_code(c);
                if (pos >= 0) close_gap(pos);
            end
            default: r.found = (find_code(c) >= 0);
        endcase
        r.red = lamps[0];
        r.yellow = lamps[1];
        r.green = lamps[2];
        r.count = 5'(active_len);
        return r;
    endfunction

    function automatic void clear_led_state();
        foreach (active_codes[i]) active_codes[i] = 4'd0;
        active_codes[0] = CODE_INIT;
        active_len = 1;
        seq_phase = SEQ_START;
        ticks_left = 16'd0;
        blinks_left = 3'd0;
        shown_code = 4'd0;
        lamps = LED_OFF;
        cfg_slow = SLOW_RST;
        cfg_pause = PAUSE_RST;
        cfg_idle = IDLE_RST;
    endfunction

    always @(posedge i_clk) begin
        t_led_request nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                led_reports_due.insert(led_reports_due.size(),
                                       next_led_state(t_op'(i_operation), i_status_code));
            end
            if (!i_in_valid || o_in_ready) begin
                if (requests_pending.size() > 0
                        && (steady_flow || $urandom_range(0, 99) >= 31)) begin
                    nxt = requests_pending.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= nxt.op;
                    i_status_code <= nxt.code;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [4:0] want, logic [4:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_led_report want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (led_reports_due.size() == 0) begin
                    $error("result beat with no expectation pending");
                    fail_count++;
                end else begin
                    want = led_reports_due.pop_front();
                    check_field("led_red", 5'(want.red), 5'(o_led_red));
                    check_field("led_yellow", 5'(want.yellow), 5'(o_led_yellow));
                    check_field("led_green", 5'(want.green), 5'(o_led_green));
                    check_field("status_found", 5'(want.found), 5'(o_status_found));
                    check_field("entry_count", want.count, o_entry_count);
                    check_field("insert_dropped", 5'(want.dropped), 5'(o_insert_dropped));
                end
            end
            i_out_ready <= steady_flow || ($urandom_range(0, 99) >= 31);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready)
                || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (requests_pending.size() != 0 || i_in_valid || led_reports_due.size() != 0);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_SLOW:  cfg_slow = val;
            CFG_PAUSE: cfg_pause = val;
            default:   cfg_idle = val;
        endcase
    endtask

    task automatic program_timing(logic [15:0] slow, logic [15:0] pause, logic [15:0] idle);
        set_reg(CFG_SLOW, slow);
        set_reg(CFG_PAUSE, pause);
        set_reg(CFG_IDLE, idle);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_request(t_op op, logic [3:0] code);
        t_led_request r;
        r.op = op;
        r.code = code;
        requests_pending.insert(requests_pending.size(), r);
    endtask

    task automatic run_phase(logic [15:0] slow, logic [15:0] pause, logic [15:0] idle,
                             int count, int mode);
        int roll;
        t_op op;
        wait_quiet();
        program_timing(slow, pause, idle);
        steady_flow = (mode == MODE_STEADY);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (mode == MODE_FILL) begin
                op = roll < 30 ? OP_TICK : roll < 80 ? OP_ADD : roll < 85 ? OP_REMOVE : OP_QUERY;
            end else begin
                op = roll < 50 ? OP_TICK : roll < 70 ? OP_ADD : roll < 85 ? OP_REMOVE : OP_QUERY;
            end
            queue_request(op, 4'($urandom_range(0, 15)));
        end
        // hold new beats until every pending result has drained
        wait_quiet();
        steady_flow = 1'b0;
    endtask

    initial begin
        clear_led_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_timing(16'd1, 16'd0, 16'd0);
        queue_request(OP_QUERY, CODE_INIT);
        queue_request(OP_QUERY, CODE_READY);
        queue_request(OP_TICK, 4'd0);
        queue_request(OP_TICK, 4'd15);
        queue_request(OP_TICK, 4'd0);
        queue_request(OP_ADD, CODE_READY);
        queue_request(OP_ADD, 4'd0);
        queue_request(OP_ADD, 4'd0);
        queue_request(OP_QUERY, CODE_READY);
        queue_request(OP_TICK, 4'd0);
        queue_request(OP_TICK, 4'd0);
        queue_request(OP_ADD, 4'd1);
        queue_request(OP_ADD, 4'd14);
        queue_request(OP_REMOVE, 4'd0);
        queue_request(OP_REMOVE, 4'd1);
        queue_request(OP_REMOVE, CODE_INIT);
        queue_request(OP_TICK, 4'd0);
        queue_request(OP_TICK, 4'd0);
        queue_request(OP_TICK, 4'd0);
        queue_request(OP_REMOVE, 4'd14);
        queue_request(OP_TICK, 4'd0);
        queue_request(OP_TICK, 4'd0);
        queue_request(OP_REMOVE, 4'd7);
        queue_request(OP_ADD, 4'd15);
        queue_request(OP_ADD, 4'd13);
        wait_quiet();

        run_phase(16'd1, 16'd0, 16'd0, 60, MODE_MIXED);
        run_phase(16'd2, 16'd1, 16'd3, 80, MODE_STEADY);
        run_phase(16'd1, 16'd2, 16'd1, 60, MODE_FILL);
        run_phase(16'd3, 16'd2, 16'd0, 60, MODE_MIXED);
        for (int p = 0; p < 3; p++) begin
            run_phase(16'($urandom_range(1, 4)), 16'($urandom_range(0, 4)),
                      16'($urandom_range(0, 4)), 40, p == 1 ? MODE_FILL : MODE_MIXED);
        end
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 20, MODE_MIXED);
        run_phase(SLOW_RST, PAUSE_RST, IDLE_RST, 15, MODE_MIXED);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && led_reports_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/slpi_pkg.sv
rtl/slpi_table_ram.sv
rtl/slpi_seq.sv
rtl/status_led_priority_indicator.sv
tb/tb_status_led_priority_indicator.sv
